// ===== hw/rtl/spp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision package
// Queue status type shared by the block's modules and a fixed width constant.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Width budget of the exact impulse product; sets the center line scaling.
  localparam int unsigned PROD_BITS = 62;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/spp_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision queue
// Two-entry queue between the classifying front end and the impulse pipeline.
// ----------------------------------------------------------------------------
module spp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  rd,
  output logic [WIDTH-1:0]      rdata,
  output spp_pkg::q_status_t    status
);
  import spp_pkg::*;

  localparam int DEPTH = 2;
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [AW:0]      count;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (rd) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata        = mem[rptr];
  assign status.full  = (count == (AW+1)'(DEPTH));
  assign status.empty = (count == '0);

endmodule

// ===== hw/rtl/spp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision front end
// Accept a pair, form the center offsets and overlap test, queue the item.
// ----------------------------------------------------------------------------
module spp_front #(
  parameter int POSITION_WIDTH = 18,
  parameter int VELOCITY_WIDTH = 20,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                              push,
  input  spp_pkg::q_status_t                q_status,
  output logic                              wr,
  input  logic signed [POSITION_WIDTH-1:0]  p1x,
  input  logic signed [POSITION_WIDTH-1:0]  p1y,
  input  logic signed [VELOCITY_WIDTH-1:0]  v1x,
  input  logic signed [VELOCITY_WIDTH-1:0]  v1y,
  input  logic [FRACTION_BITS-1:0]          h1,
  input  logic signed [POSITION_WIDTH-1:0]  p2x,
  input  logic signed [POSITION_WIDTH-1:0]  p2y,
  input  logic signed [VELOCITY_WIDTH-1:0]  v2x,
  input  logic signed [VELOCITY_WIDTH-1:0]  v2y,
  input  logic [FRACTION_BITS-1:0]          h2,
  output logic                              hit,
  output logic signed [POSITION_WIDTH:0]    dx,
  output logic signed [POSITION_WIDTH:0]    dy,
  output logic [POSITION_WIDTH:0]           ax,
  output logic [POSITION_WIDTH:0]           ay,
  output logic [FRACTION_BITS:0]            ext,
  output logic signed [VELOCITY_WIDTH:0]    dux,
  output logic signed [VELOCITY_WIDTH:0]    duy
);
  import spp_pkg::*;

  localparam int P  = POSITION_WIDTH;
  localparam int V  = VELOCITY_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int CW = (P + 1 > F + 1) ? P + 1 : F + 1;

  assign wr = push && !q_status.full;

  always_comb begin
    dx  = (P+1)'(p1x) - (P+1)'(p2x);
    dy  = (P+1)'(p1y) - (P+1)'(p2y);
    ax  = dx[P] ? (P+1)'(-dx) : (P+1)'(dx);
    ay  = dy[P] ? (P+1)'(-dy) : (P+1)'(dy);
    ext = (F+1)'(h1) + (F+1)'(h2);
    hit = (CW'(ax) < CW'(ext)) && (CW'(ay) < CW'(ext));
    dux = (V+1)'(v1x) - (V+1)'(v2x);
    duy = (V+1)'(v1y) - (V+1)'(v2y);
  end

endmodule

// ===== hw/rtl/spp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision back end
// Push-out, impulse products and a bit-per-stage divider, one item per cycle while pop keeps up.
// ----------------------------------------------------------------------------
module spp_back #(
  parameter int POSITION_WIDTH = 18,
  parameter int VELOCITY_WIDTH = 20,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  spp_pkg::q_status_t                q_status,
  output logic                              q_rd,
  input  logic                              hit,
  input  logic signed [POSITION_WIDTH-1:0]  p1x,
  input  logic signed [POSITION_WIDTH-1:0]  p1y,
  input  logic signed [VELOCITY_WIDTH-1:0]  v1x,
  input  logic signed [VELOCITY_WIDTH-1:0]  v1y,
  input  logic signed [VELOCITY_WIDTH-1:0]  v2x,
  input  logic signed [VELOCITY_WIDTH-1:0]  v2y,
  input  logic signed [POSITION_WIDTH:0]    dx,
  input  logic signed [POSITION_WIDTH:0]    dy,
  input  logic [POSITION_WIDTH:0]           ax,
  input  logic [POSITION_WIDTH:0]           ay,
  input  logic [FRACTION_BITS:0]            ext,
  input  logic signed [VELOCITY_WIDTH:0]    dux,
  input  logic signed [VELOCITY_WIDTH:0]    duy,
  output logic                              out_valid,
  input  logic                              pop,
  output logic                              collided,
  output logic signed [POSITION_WIDTH-1:0]  npx,
  output logic signed [POSITION_WIDTH-1:0]  npy,
  output logic signed [VELOCITY_WIDTH-1:0]  n1x,
  output logic signed [VELOCITY_WIDTH-1:0]  n1y,
  output logic signed [VELOCITY_WIDTH-1:0]  n2x,
  output logic signed [VELOCITY_WIDTH-1:0]  n2y
);
  import spp_pkg::*;

  localparam int P   = POSITION_WIDTH;
  localparam int V   = VELOCITY_WIDTH;
  localparam int F   = FRACTION_BITS;
  localparam int MAG = (PROD_BITS - V) / 2;
  localparam int S   = (P > MAG) ? P - MAG : 0;
  localparam int E   = P + 1 - S;
  localparam int CW  = (P + 1 > F + 1) ? P + 1 : F + 1;
  localparam int PSW = F + 2;
  localparam int SW  = ((P > F + 2) ? P : F + 2) + 1;
  localparam int Q   = V + 2;
  localparam int NW  = V + E + 1;
  localparam int L   = NW / 2;
  localparam int H   = NW - L;
  localparam int DW  = 2 * E;
  localparam int RW  = V + 2 * E + 2;
  localparam int VW  = V + 4;
  localparam logic [P:0] EX_BIAS = (P+1)'((1 << S) - 1);

  typedef struct packed {
    logic                hit;
    logic signed [P-1:0] px;
    logic signed [P-1:0] py;
    logic signed [V-1:0] v1x;
    logic signed [V-1:0] v1y;
    logic signed [V-1:0] v2x;
    logic signed [V-1:0] v2y;
  } carry_t;

  function automatic logic signed [P-1:0] sat_pos(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] pmax;
    logic signed [SW-1:0] pmin;
    pmax = SW'({1'b0, {(P-1){1'b1}}});
    pmin = ~pmax;
    if (v > pmax) return pmax[P-1:0];
    if (v < pmin) return pmin[P-1:0];
    return v[P-1:0];
  endfunction

  function automatic logic signed [V-1:0] sat_vel(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] vmax;
    logic signed [VW-1:0] vmin;
    vmax = VW'({1'b0, {(V-1){1'b1}}});
    vmin = ~vmax;
    if (v > vmax) return vmax[V-1:0];
    if (v < vmin) return vmin[V-1:0];
    return v[V-1:0];
  endfunction

  logic adv;
  assign adv  = !out_valid || pop;
  assign q_rd = adv && !q_status.empty;

  // stage A: push amounts, scaled center line
  logic [CW-1:0]         sx_w, sy_w;
  logic                  pickx;
  logic signed [PSW-1:0] magx, magy, pushx_w, pushy_w;
  logic [P:0]            dxb, dyb;

  always_comb begin
    sx_w    = CW'(ext) - CW'(ax);
    sy_w    = CW'(ext) - CW'(ay);
    pickx   = sx_w < sy_w;
    magx    = PSW'({1'b0, sx_w[F:0]});
    magy    = PSW'({1'b0, sy_w[F:0]});
    pushx_w = pickx ? (dx[P] ? -magx : magx) : '0;
    pushy_w = pickx ? '0 : (dy[P] ? -magy : magy);
    dxb     = dx + (dx[P] ? EX_BIAS : '0);
    dyb     = dy + (dy[P] ? EX_BIAS : '0);
  end

  logic                  a_valid;
  carry_t                a_c;
  logic signed [PSW-1:0] a_pushx, a_pushy;
  logic signed [E-1:0]   a_ex, a_ey;
  logic signed [V:0]     a_dux, a_duy;

  // stage B
  logic                  b_valid;
  carry_t                b_c;
  logic signed [V+E:0]   b_mxx, b_myy;
  logic signed [DW-1:0]  b_sqx, b_sqy;
  logic signed [E-1:0]   b_ex, b_ey;
  logic signed [SW-1:0]  sumx, sumy;

  assign sumx = SW'(a_c.px) + SW'(a_pushx);
  assign sumy = SW'(a_c.py) + SW'(a_pushy);

  // stage C
  logic                  c_valid;
  carry_t                c_c;
  logic signed [NW-1:0]  c_num;
  logic [DW-1:0]         c_den;
  logic signed [E-1:0]   c_ex, c_ey;

  // stage D
  logic                  d_valid;
  carry_t                d_c;
  logic [NW-1:0]         d_anum;
  logic [E-1:0]          d_aex, d_aey;
  logic                  d_sgx, d_sgy, d_dz;
  logic [DW-1:0]         d_den;

  // stage E
  logic                  e_valid;
  carry_t                e_c;
  logic [L+E-1:0]        e_plox, e_ploy;
  logic [H+E-1:0]        e_phix, e_phiy;
  logic                  e_sgx, e_sgy, e_dz;
  logic [DW-1:0]         e_den;

  // divider pipeline, index 0 holds the dividend
  logic                  r_valid [0:Q];
  carry_t                r_c     [0:Q];
  logic [RW-1:0]         r_remx  [0:Q];
  logic [RW-1:0]         r_remy  [0:Q];
  logic [Q-1:0]          r_qx    [0:Q];
  logic [Q-1:0]          r_qy    [0:Q];
  logic [DW-1:0]         r_den   [0:Q];
  logic                  r_sgx   [0:Q];
  logic                  r_sgy   [0:Q];
  logic                  r_dz    [0:Q];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_c       <= '{hit: hit, px: p1x, py: p1y, v1x: v1x, v1y: v1y, v2x: v2x, v2y: v2y};
      a_pushx   <= pushx_w;
      a_pushy   <= pushy_w;
      a_ex      <= E'(dxb[P:S]);
      a_ey      <= E'(dyb[P:S]);
      a_dux     <= dux;
      a_duy     <= duy;

      b_c       <= '{hit: a_c.hit,
                     px:  a_c.hit ? sat_pos(sumx) : a_c.px,
                     py:  a_c.hit ? sat_pos(sumy) : a_c.py,
                     v1x: a_c.v1x, v1y: a_c.v1y, v2x: a_c.v2x, v2y: a_c.v2y};
      b_mxx     <= a_dux * a_ex;
      b_myy     <= a_duy * a_ey;
      b_sqx     <= a_ex * a_ex;
      b_sqy     <= a_ey * a_ey;
      b_ex      <= a_ex;
      b_ey      <= a_ey;

      c_c       <= b_c;
      c_num     <= NW'(b_mxx) + NW'(b_myy);
      c_den     <= $unsigned(b_sqx) + $unsigned(b_sqy);
      c_ex      <= b_ex;
      c_ey      <= b_ey;

      d_c       <= c_c;
      d_anum    <= c_num[NW-1] ? NW'(-c_num) : NW'(c_num);
      d_aex     <= c_ex[E-1] ? E'(-c_ex) : E'(c_ex);
      d_aey     <= c_ey[E-1] ? E'(-c_ey) : E'(c_ey);
      d_sgx     <= c_num[NW-1] ^ c_ex[E-1];
      d_sgy     <= c_num[NW-1] ^ c_ey[E-1];
      d_dz      <= (c_den == '0);
      d_den     <= c_den;

      e_c       <= d_c;
      e_plox    <= d_anum[L-1:0] * d_aex;
      e_phix    <= d_anum[NW-1:L] * d_aex;
      e_ploy    <= d_anum[L-1:0] * d_aey;
      e_phiy    <= d_anum[NW-1:L] * d_aey;
      e_sgx     <= d_sgx;
      e_sgy     <= d_sgy;
      e_dz      <= d_dz;
      e_den     <= d_den;

      r_c[0]    <= e_c;
      r_remx[0] <= RW'({e_phix, {L{1'b0}}}) + RW'(e_plox);
      r_remy[0] <= RW'({e_phiy, {L{1'b0}}}) + RW'(e_ploy);
      r_qx[0]   <= '0;
      r_qy[0]   <= '0;
      r_den[0]  <= e_den;
      r_sgx[0]  <= e_sgx;
      r_sgy[0]  <= e_sgy;
      r_dz[0]   <= e_dz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      c_valid    <= 1'b0;
      d_valid    <= 1'b0;
      e_valid    <= 1'b0;
      r_valid[0] <= 1'b0;
    end else if (adv) begin
      a_valid    <= !q_status.empty;
      b_valid    <= a_valid;
      c_valid    <= b_valid;
      d_valid    <= c_valid;
      e_valid    <= d_valid;
      r_valid[0] <= e_valid;
    end
  end

  for (genvar k = 0; k < Q; k++) begin : g_div
    logic [RW-1:0] dsh;
    logic          gex, gey;

    assign dsh = RW'(r_den[k]) << (Q - 1 - k);
    assign gex = r_remx[k] >= dsh;
    assign gey = r_remy[k] >= dsh;

    always_ff @(posedge clk) begin
      if (adv) begin
        r_c[k+1]    <= r_c[k];
        r_remx[k+1] <= gex ? r_remx[k] - dsh : r_remx[k];
        r_remy[k+1] <= gey ? r_remy[k] - dsh : r_remy[k];
        r_qx[k+1]   <= {r_qx[k][Q-2:0], gex};
        r_qy[k+1]   <= {r_qy[k][Q-2:0], gey};
        r_den[k+1]  <= r_den[k];
        r_sgx[k+1]  <= r_sgx[k];
        r_sgy[k+1]  <= r_sgy[k];
        r_dz[k+1]   <= r_dz[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        r_valid[k+1] <= 1'b0;
      end else if (adv) begin
        r_valid[k+1] <= r_valid[k];
      end
    end
  end

  // final stage: apply the exchange and saturate
  logic signed [Q:0] qvx, qvy, dvx, dvy;

  always_comb begin
    qvx = (Q+1)'({1'b0, r_qx[Q]});
    qvy = (Q+1)'({1'b0, r_qy[Q]});
    dvx = r_dz[Q] ? '0 : (r_sgx[Q] ? -qvx : qvx);
    dvy = r_dz[Q] ? '0 : (r_sgy[Q] ? -qvy : qvy);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      collided <= r_c[Q].hit;
      npx      <= r_c[Q].px;
      npy      <= r_c[Q].py;
      n1x      <= r_c[Q].hit ? sat_vel(VW'(r_c[Q].v1x) - VW'(dvx)) : r_c[Q].v1x;
      n1y      <= r_c[Q].hit ? sat_vel(VW'(r_c[Q].v1y) - VW'(dvy)) : r_c[Q].v1y;
      n2x      <= r_c[Q].hit ? sat_vel(VW'(r_c[Q].v2x) + VW'(dvx)) : r_c[Q].v2x;
      n2y      <= r_c[Q].hit ? sat_vel(VW'(r_c[Q].v2y) + VW'(dvy)) : r_c[Q].v2y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= r_valid[Q];
    end
  end

  a_one_push : assert property (@(posedge clk) disable iff (rst)
    a_valid && a_c.hit |-> $onehot({a_pushx != '0, a_pushy != '0}))
    else $error("collision pushes along both or neither axis");

  a_dz_zero : assert property (@(posedge clk) disable iff (rst)
    d_valid && d_dz |-> (d_aex == '0) && (d_aey == '0))
    else $error("zero center distance with nonzero offset");

  a_rem_x : assert property (@(posedge clk) disable iff (rst)
    r_valid[Q] && !r_dz[Q] |-> r_remx[Q] < RW'(r_den[Q]))
    else $error("x quotient overflowed the divider");

  a_rem_y : assert property (@(posedge clk) disable iff (rst)
    r_valid[Q] && !r_dz[Q] |-> r_remy[Q] < RW'(r_den[Q]))
    else $error("y quotient overflowed the divider");

endmodule

// ===== hw/rtl/square_particle_pair_collision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision
// Accepts one particle pair per cycle while pop keeps up and returns one
// result per pair, in order. The pipeline depth comes from the restoring
// divider of the impulse, one quotient bit per stage, which is fully
// pipelined and so keeps the rate at one pair per cycle while pop keeps up.
// Positions and half sizes are Q2.16 and Q0.16, velocities Q4.16, all
// outputs saturate, and a pair that does not overlap passes through.
// ----------------------------------------------------------------------------
module square_particle_pair_collision #(
  parameter int POSITION_WIDTH = 18,
  parameter int VELOCITY_WIDTH = 20,
  parameter int FRACTION_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [POSITION_WIDTH-1:0]  first_pos_x,
  input  logic signed [POSITION_WIDTH-1:0]  first_pos_y,
  input  logic signed [VELOCITY_WIDTH-1:0]  first_vel_x,
  input  logic signed [VELOCITY_WIDTH-1:0]  first_vel_y,
  input  logic [FRACTION_BITS-1:0]          first_half_size,
  input  logic signed [POSITION_WIDTH-1:0]  second_pos_x,
  input  logic signed [POSITION_WIDTH-1:0]  second_pos_y,
  input  logic signed [VELOCITY_WIDTH-1:0]  second_vel_x,
  input  logic signed [VELOCITY_WIDTH-1:0]  second_vel_y,
  input  logic [FRACTION_BITS-1:0]          second_half_size,
  output logic                              empty,
  input  logic                              pop,
  output logic                              collided,
  output logic signed [POSITION_WIDTH-1:0]  new_first_pos_x,
  output logic signed [POSITION_WIDTH-1:0]  new_first_pos_y,
  output logic signed [VELOCITY_WIDTH-1:0]  new_first_vel_x,
  output logic signed [VELOCITY_WIDTH-1:0]  new_first_vel_y,
  output logic signed [VELOCITY_WIDTH-1:0]  new_second_vel_x,
  output logic signed [VELOCITY_WIDTH-1:0]  new_second_vel_y
);
  import spp_pkg::*;

  localparam int P  = POSITION_WIDTH;
  localparam int V  = VELOCITY_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int QW = 1 + 2 * P + 4 * V + 4 * (P + 1) + (F + 1) + 2 * (V + 1);

  q_status_t q_status;
  logic      wr, rd, out_valid;
  logic [QW-1:0] wdata, rdata;

  logic                f_hit, b_hit;
  logic signed [P:0]   f_dx, f_dy, b_dx, b_dy;
  logic [P:0]          f_ax, f_ay, b_ax, b_ay;
  logic [F:0]          f_ext, b_ext;
  logic signed [V:0]   f_dux, f_duy, b_dux, b_duy;
  logic signed [P-1:0] b_p1x, b_p1y;
  logic signed [V-1:0] b_v1x, b_v1y, b_v2x, b_v2y;

  spp_front #(
    .POSITION_WIDTH (P),
    .VELOCITY_WIDTH (V),
    .FRACTION_BITS  (F)
  ) u_front (
    .push     (push),
    .q_status (q_status),
    .wr       (wr),
    .p1x      (first_pos_x),
    .p1y      (first_pos_y),
    .v1x      (first_vel_x),
    .v1y      (first_vel_y),
    .h1       (first_half_size),
    .p2x      (second_pos_x),
    .p2y      (second_pos_y),
    .v2x      (second_vel_x),
    .v2y      (second_vel_y),
    .h2       (second_half_size),
    .hit      (f_hit),
    .dx       (f_dx),
    .dy       (f_dy),
    .ax       (f_ax),
    .ay       (f_ay),
    .ext      (f_ext),
    .dux      (f_dux),
    .duy      (f_duy)
  );

  assign wdata = {f_hit, first_pos_x, first_pos_y, first_vel_x, first_vel_y,
                  second_vel_x, second_vel_y, f_dx, f_dy, f_ax, f_ay, f_ext,
                  f_dux, f_duy};

  spp_fifo #(
    .WIDTH (QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .wdata  (wdata),
    .rd     (rd),
    .rdata  (rdata),
    .status (q_status)
  );

  assign {b_hit, b_p1x, b_p1y, b_v1x, b_v1y, b_v2x, b_v2y, b_dx, b_dy, b_ax, b_ay,
          b_ext, b_dux, b_duy} = rdata;

  spp_back #(
    .POSITION_WIDTH (P),
    .VELOCITY_WIDTH (V),
    .FRACTION_BITS  (F)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .q_rd      (rd),
    .hit       (b_hit),
    .p1x       (b_p1x),
    .p1y       (b_p1y),
    .v1x       (b_v1x),
    .v1y       (b_v1y),
    .v2x       (b_v2x),
    .v2y       (b_v2y),
    .dx        (b_dx),
    .dy        (b_dy),
    .ax        (b_ax),
    .ay        (b_ay),
    .ext       (b_ext),
    .dux       (b_dux),
    .duy       (b_duy),
    .out_valid (out_valid),
    .pop       (pop),
    .collided  (collided),
    .npx       (new_first_pos_x),
    .npy       (new_first_pos_y),
    .n1x       (new_first_vel_x),
    .n1y       (new_first_vel_y),
    .n2x       (new_second_vel_x),
    .n2y       (new_second_vel_y)
  );

  assign full  = q_status.full;
  assign empty = !out_valid;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square particle pair collision testbench
// Streams directed and random particle pairs through the block, predicts
// each collision result in the bench, and compares every result field with
// the oldest prediction. Both push and pop idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PW = 18;
  localparam int VW = 20;
  localparam int FW = 16;
  localparam int NUM_RANDOM = 1050;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic signed [PW-1:0] p1x, p1y, p2x, p2y;
    logic signed [VW-1:0] v1x, v1y, v2x, v2y;
    logic [FW-1:0]        h1, h2;
  } pair_t;

  typedef struct {
    logic                 hit;
    logic signed [PW-1:0] px, py;
    logic signed [VW-1:0] v1x, v1y, v2x, v2y;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, collided;
  logic signed [PW-1:0] first_pos_x = '0, first_pos_y = '0;
  logic signed [PW-1:0] second_pos_x = '0, second_pos_y = '0;
  logic signed [VW-1:0] first_vel_x = '0, first_vel_y = '0;
  logic signed [VW-1:0] second_vel_x = '0, second_vel_y = '0;
  logic [FW-1:0] first_half_size = '0, second_half_size = '0;
  logic signed [PW-1:0] new_first_pos_x, new_first_pos_y;
  logic signed [VW-1:0] new_first_vel_x, new_first_vel_y;
  logic signed [VW-1:0] new_second_vel_x, new_second_vel_y;

  pair_t    pending_pairs[$];
  outcome_t expected_outcomes[$];
  int       errors = 0;
  int       cycle = 0;
  int       stall_cycles = 0;

  square_particle_pair_collision u_top (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .first_pos_x(first_pos_x), .first_pos_y(first_pos_y),
    .first_vel_x(first_vel_x), .first_vel_y(first_vel_y),
    .first_half_size(first_half_size),
    .second_pos_x(second_pos_x), .second_pos_y(second_pos_y),
    .second_vel_x(second_vel_x), .second_vel_y(second_vel_y),
    .second_half_size(second_half_size),
    .empty(empty), .pop(pop), .collided(collided),
    .new_first_pos_x(new_first_pos_x), .new_first_pos_y(new_first_pos_y),
    .new_first_vel_x(new_first_vel_x), .new_first_vel_y(new_first_vel_y),
    .new_second_vel_x(new_second_vel_x), .new_second_vel_y(new_second_vel_y)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp(longint v, int w);
    longint hi;
    hi = (longint'(1) << (w - 1)) - 1;
    if (v > hi) return hi;
    if (v < -hi - 1) return -hi - 1;
    return v;
  endfunction

  function automatic outcome_t resolve_pair(pair_t p);
    outcome_t r;
    longint dx, dy, ax, ay, ext, sx, sy, den, num, dvx, dvy;
    dx = longint'(p.p1x) - longint'(p.p2x);
    dy = longint'(p.p1y) - longint'(p.p2y);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    ext = longint'(p.h1) + longint'(p.h2);
    r.hit = (ax < ext) && (ay < ext);
    r.px = p.p1x; r.py = p.p1y;
    r.v1x = p.v1x; r.v1y = p.v1y; r.v2x = p.v2x; r.v2y = p.v2y;
    if (r.hit) begin
      sx = ext - ax;
      sy = ext - ay;
      if (sx < sy) sy = 0;
      else sx = 0;
      if (dx < 0) sx = -sx;
      if (dy < 0) sy = -sy;
      r.px = PW'(clamp(longint'(p.p1x) + sx, PW));
      r.py = PW'(clamp(longint'(p.p1y) + sy, PW));
      den = dx * dx + dy * dy;
      dvx = 0;
      dvy = 0;
      if (den != 0) begin
        num = (longint'(p.v1x) - longint'(p.v2x)) * dx
            + (longint'(p.v1y) - longint'(p.v2y)) * dy;
        dvx = (num * dx) / den;
        dvy = (num * dy) / den;
      end
      r.v1x = VW'(clamp(longint'(p.v1x) - dvx, VW));
      r.v1y = VW'(clamp(longint'(p.v1y) - dvy, VW));
      r.v2x = VW'(clamp(longint'(p.v2x) + dvx, VW));
      r.v2y = VW'(clamp(longint'(p.v2y) + dvy, VW));
    end
    return r;
  endfunction

  function automatic void compare_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function automatic bit idle_now();
    if (cycle > 400 && cycle < 700) return 1'b0;
    return $urandom_range(99) < 19;
  endfunction

  function automatic pair_t make_pair(longint p1x, longint p1y, longint p2x, longint p2y,
                                      longint v1x, longint v1y, longint v2x, longint v2y,
                                      longint h1, longint h2);
    pair_t p;
    p.p1x = PW'(p1x); p.p1y = PW'(p1y); p.p2x = PW'(p2x); p.p2y = PW'(p2y);
    p.v1x = VW'(v1x); p.v1y = VW'(v1y); p.v2x = VW'(v2x); p.v2y = VW'(v2y);
    p.h1 = FW'(h1); p.h2 = FW'(h2);
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    p.p1x = PW'($urandom); p.p1y = PW'($urandom);
    p.v1x = VW'($urandom); p.v1y = VW'($urandom);
    p.v2x = VW'($urandom); p.v2y = VW'($urandom);
    p.h1 = FW'($urandom); p.h2 = FW'($urandom);
    if ($urandom_range(99) < 75) begin
      // place the second center near the first so that pairs often overlap
      p.p2x = p.p1x + PW'($urandom_range(262144) - 131072);
      p.p2y = p.p1y + PW'($urandom_range(262144) - 131072);
      if ($urandom_range(9) == 0) p.p2y = p.p1y;
      if ($urandom_range(19) == 0) p.p2x = p.p1x;
    end else begin
      p.p2x = PW'($urandom); p.p2y = PW'($urandom);
    end
    return p;
  endfunction

  // Driver: present the head of the pending queue, advance on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_outcomes.push_back(resolve_pair(pending_pairs.pop_front()));
      end
      if (pending_pairs.size() > 0 && !idle_now()) begin
        push <= 1'b1;
        first_pos_x <= pending_pairs[0].p1x;
        first_pos_y <= pending_pairs[0].p1y;
        first_vel_x <= pending_pairs[0].v1x;
        first_vel_y <= pending_pairs[0].v1y;
        first_half_size <= pending_pairs[0].h1;
        second_pos_x <= pending_pairs[0].p2x;
        second_pos_y <= pending_pairs[0].p2y;
        second_vel_x <= pending_pairs[0].v2x;
        second_vel_y <= pending_pairs[0].v2y;
        second_half_size <= pending_pairs[0].h2;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Monitor: check each popped result against the oldest prediction.
  always @(posedge clk) begin
    outcome_t e;
    cycle <= cycle + 1;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_outcomes.size() == 0) begin
          $error("result popped with no prediction waiting");
          errors++;
        end else begin
          e = expected_outcomes.pop_front();
          compare_field("collided", longint'(e.hit), longint'(collided));
          compare_field("new_first_pos_x", longint'(e.px), longint'(new_first_pos_x));
          compare_field("new_first_pos_y", longint'(e.py), longint'(new_first_pos_y));
          compare_field("new_first_vel_x", longint'(e.v1x), longint'(new_first_vel_x));
          compare_field("new_first_vel_y", longint'(e.v1y), longint'(new_first_vel_y));
          compare_field("new_second_vel_x", longint'(e.v2x), longint'(new_second_vel_x));
          compare_field("new_second_vel_y", longint'(e.v2y), longint'(new_second_vel_y));
        end
      end
      pop <= !idle_now();
      if ((push && !full) || (pop && !empty)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    // no overlap, all-zero, extremes, coincident centers, saturation
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 5, -7, 3, 9, 1, 0));
    pending_pairs.push_back(make_pair(100, 200, 100, 200, 524287, -524288, -524288, 524287,
                                      65535, 65535));
    pending_pairs.push_back(make_pair(131071, 131071, -131072, -131072, 524287, 524287,
                                      -524288, -524288, 65535, 65535));
    pending_pairs.push_back(make_pair(131071, 0, 131000, 0, 524287, 0, -524288, 0,
                                      65535, 65535));
    pending_pairs.push_back(make_pair(-131072, 0, -131000, 0, -524288, 0, 524287, 0,
                                      65535, 65535));
    pending_pairs.push_back(make_pair(0, 131071, 0, 131000, 0, 524287, 0, -524288,
                                      65535, 65535));
    pending_pairs.push_back(make_pair(0, -131072, 0, -131000, 0, -524288, 0, 524287,
                                      65535, 65535));
    pending_pairs.push_back(make_pair(1000, 500, 0, 0, 65536, 0, -65536, 0, 600, 600));
    pending_pairs.push_back(make_pair(500, 1000, 0, 0, 0, 65536, 0, -65536, 600, 600));
    pending_pairs.push_back(make_pair(700, 700, 0, 0, 1234, -4321, 77, 88, 400, 400));
    pending_pairs.push_back(make_pair(-700, -300, 0, 0, 1, 2, 3, 4, 400, 400));
    pending_pairs.push_back(make_pair(800, 0, 0, 0, 9, 9, 9, 9, 400, 400));
    pending_pairs.push_back(make_pair(800, 0, 0, 0, 9, 9, 9, 9, 400, 401));
    pending_pairs.push_back(make_pair(0, 0, 65535, 65535, 1, 1, 1, 1, 65535, 0));
    pending_pairs.push_back(make_pair(0, 0, 65535, 65535, 1, 1, 1, 1, 65535, 1));
    pending_pairs.push_back(make_pair(131071, -131072, 131071, -131072, -1, -1, 1, 1,
                                      0, 65535));
    pending_pairs.push_back(make_pair(3, -5, -2, 7, 524287, -524288, -524288, 524287,
                                      65535, 65535));
    for (int i = 0; i < NUM_RANDOM; i++) pending_pairs.push_back(random_pair());
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    wait (pending_pairs.size() == 0 && expected_outcomes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_outcomes.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
